/* rtl/nltj_pkg.sv */
// Shared constants and codes for the nested-loop table join engine.
package nltj_pkg;

   localparam int NUM_FIELDS   = 10;
   localparam int VAL_W        = 32;
   localparam int ROW_IDX_W    = 5;
   localparam int COL_W        = 4;
   localparam int ACTION_W     = 2;
   localparam int CSR_IDX_W    = 2;

   localparam int DEF_MAX_COLS = 10;
   localparam int DEF_MAX_ROWS = 32;

   localparam int REQ_TDATA_W  = NUM_FIELDS * VAL_W;
   localparam int RSP_PAY_W    = NUM_FIELDS * VAL_W + ROW_IDX_W;
   localparam int RSP_TDATA_W  = ((RSP_PAY_W + 7) / 8) * 8;

   typedef logic [ACTION_W-1:0]  action_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [COL_W-1:0]     col_type;

   localparam action_type ACT_CLEAR = 2'd0;
   localparam action_type ACT_LOAD  = 2'd1;
   localparam action_type ACT_PROBE = 2'd2;

   localparam csr_idx_type CSR_KEY_COL_PROBE  = 2'd0;
   localparam csr_idx_type CSR_KEY_COL_STORED = 2'd1;
   localparam csr_idx_type CSR_COLS_STORED    = 2'd2;

   localparam col_type COLS_RESET = 4'd10;

endpackage

/* rtl/nltj_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nltj_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/nested_loop_table_join_top.sv */
// Nested-loop equi-join engine: row store walk, key compare and result register.
// Clear and load requests leave the engine idle. A probe runs through the accept cycle,
// one row memory read per cycle while the result side does not stall, one compare
// stage behind the reads and a closing step that sends the held last match. Reset
// clears the row count and sets the registers to their defaults; the row memory is not
// cleared and is read only below the count.
module nested_loop_table_join_top #(
   parameter int MAX_COLS = nltj_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = nltj_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: in_value_0 .. in_value_9, 32 bits each from bit 0 up
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [nltj_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: action
   input  logic [nltj_pkg::ACTION_W-1:0]    req_tuser,
   // rsp_tdata: out_value_0 .. out_value_9 (32 bits each), match_row, zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nltj_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nltj_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nltj_pkg::COL_W-1:0]       csr_data
);

   import nltj_pkg::*;

   localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = $clog2(MAX_ROWS + 1);
   localparam int ROW_W = MAX_COLS * VAL_W;
   localparam int ROWX_W = CW + ROW_IDX_W;
   localparam int OUT_W = NUM_FIELDS * VAL_W;

   localparam logic [CW-1:0]    ROWS_C = CW'(MAX_ROWS);
   localparam logic [COL_W-1:0] COLS_C = COL_W'(MAX_COLS);
   localparam logic [COL_W-1:0] FIELDS_C = COL_W'(NUM_FIELDS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic             state_ff, state_in;
   logic [CW-1:0]    row_count_ff, row_count_in;
   col_type          key_probe_cfg_ff, key_probe_cfg_in;
   col_type          key_stored_cfg_ff, key_stored_cfg_in;
   col_type          cols_cfg_ff, cols_cfg_in;
   logic [VAL_W-1:0] probe_key_ff, probe_key_in;
   logic [CW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [CW-1:0]    chk_row_ff, chk_row_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [OUT_W-1:0] pend_data_ff, pend_data_in;
   logic [ROW_IDX_W-1:0] pend_row_ff, pend_row_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [OUT_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ROW_IDX_W-1:0] rsp_row_ff, rsp_row_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_acc;
   logic             wr_en;
   logic             rd_en;
   logic [ROW_W-1:0] wr_row;
   logic [ROW_W-1:0] rd_row;
   logic [OUT_W-1:0] masked_row;
   col_type          valid_cols;
   logic [VAL_W-1:0] stored_key;
   logic [VAL_W-1:0] req_key;
   logic             is_match;
   logic             out_free;
   logic             stall;
   logic             advance;
   logic             walk_done;
   logic [ROWX_W-1:0] chk_row_ext;

   assign valid_cols = (cols_cfg_ff > COLS_C) ? COLS_C : cols_cfg_ff;
   assign wr_row     = req_tdata[ROW_W-1:0];

   // Stored columns at or past the valid count read as zero.
   for (genvar c = 0; c < NUM_FIELDS; c++) begin : g_mask
      if (c < MAX_COLS) begin : g_col
         assign masked_row[c*VAL_W +: VAL_W] =
            (COL_W'(c) < valid_cols) ? rd_row[c*VAL_W +: VAL_W] : '0;
      end else begin : g_zero
         assign masked_row[c*VAL_W +: VAL_W] = '0;
      end
   end

   assign stored_key = (key_stored_cfg_ff < FIELDS_C)
                     ? masked_row[key_stored_cfg_ff*VAL_W +: VAL_W] : '0;
   assign req_key    = (key_probe_cfg_ff < COLS_C && key_probe_cfg_ff < FIELDS_C)
                     ? req_tdata[key_probe_cfg_ff*VAL_W +: VAL_W] : '0;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign wr_en      = req_acc && (req_tuser == ACT_LOAD) && (row_count_ff < ROWS_C);

   assign is_match  = chk_vld_ff && (stored_key == probe_key_ff);
   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign stall     = is_match && pend_vld_ff && !out_free;
   assign advance   = (state_ff == ST_WALK) && !stall;
   assign rd_en     = advance && (rd_ptr_ff < row_count_ff);
   assign walk_done = (state_ff == ST_WALK) && !chk_vld_ff && (rd_ptr_ff == row_count_ff);
   assign chk_row_ext = ROWX_W'(chk_row_ff);

   nltj_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_count_ff[AW-1:0]),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_row)
   );

   always_comb begin
      state_in          = state_ff;
      row_count_in      = row_count_ff;
      key_probe_cfg_in  = key_probe_cfg_ff;
      key_stored_cfg_in = key_stored_cfg_ff;
      cols_cfg_in       = cols_cfg_ff;
      probe_key_in      = probe_key_ff;
      rd_ptr_in         = rd_ptr_ff;
      chk_vld_in        = chk_vld_ff;
      chk_row_in        = chk_row_ff;
      pend_vld_in       = pend_vld_ff;
      pend_data_in      = pend_data_ff;
      pend_row_in       = pend_row_ff;
      rsp_vld_in        = rsp_vld_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      rsp_row_in        = rsp_row_ff;
      rsp_last_in       = rsp_last_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_COL_PROBE:  key_probe_cfg_in  = csr_data;
            CSR_KEY_COL_STORED: key_stored_cfg_in = csr_data;
            CSR_COLS_STORED:    cols_cfg_in       = csr_data;
            default: ;
         endcase
      end

      if (req_acc) begin
         unique case (req_tuser)
            ACT_CLEAR: row_count_in = '0;
            ACT_LOAD: begin
               if (wr_en) begin
                  row_count_in = row_count_ff + 1'b1;
               end
            end
            ACT_PROBE: begin
               probe_key_in = req_key;
               rd_ptr_in    = '0;
               chk_vld_in   = 1'b0;
               pend_vld_in  = 1'b0;
               state_in     = ST_WALK;
            end
            default: ;
         endcase
      end

      if (advance) begin
         chk_vld_in = rd_en;
         chk_row_in = rd_ptr_ff;
         if (rd_en) begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
         // Hold one match back so the final one can be marked last.
         if (is_match) begin
            if (pend_vld_ff) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = pend_data_ff;
               rsp_row_in  = pend_row_ff;
               rsp_last_in = 1'b0;
            end
            pend_vld_in  = 1'b1;
            pend_data_in = masked_row;
            pend_row_in  = chk_row_ext[ROW_IDX_W-1:0];
         end
      end

      if (walk_done) begin
         if (!pend_vld_ff) begin
            state_in = ST_IDLE;
         end else if (out_free) begin
            rsp_vld_in  = 1'b1;
            rsp_data_in = pend_data_ff;
            rsp_row_in  = pend_row_ff;
            rsp_last_in = 1'b1;
            pend_vld_in = 1'b0;
            state_in    = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         row_count_ff      <= '0;
         key_probe_cfg_ff  <= '0;
         key_stored_cfg_ff <= '0;
         cols_cfg_ff       <= COLS_RESET;
         chk_vld_ff        <= 1'b0;
         pend_vld_ff       <= 1'b0;
         rsp_vld_ff        <= 1'b0;
         rd_ptr_ff         <= '0;
      end else begin
         state_ff          <= state_in;
         row_count_ff      <= row_count_in;
         key_probe_cfg_ff  <= key_probe_cfg_in;
         key_stored_cfg_ff <= key_stored_cfg_in;
         cols_cfg_ff       <= cols_cfg_in;
         chk_vld_ff        <= chk_vld_in;
         pend_vld_ff       <= pend_vld_in;
         rsp_vld_ff        <= rsp_vld_in;
         rd_ptr_ff         <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_key_ff <= probe_key_in;
      chk_row_ff   <= chk_row_in;
      pend_data_ff <= pend_data_in;
      pend_row_ff  <= pend_row_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_PAY_W){1'b0}}, rsp_row_ff, rsp_data_ff};

endmodule
